FILE: design/tht_pkg.sv
package tht_pkg;

  typedef enum logic [3:0] {
    OP_CREATE     = 4'd0,
    OP_CLOSE      = 4'd1,
    OP_EXISTS     = 4'd2,
    OP_GET_INFO   = 4'd3,
    OP_FIRST      = 4'd4,
    OP_NEXT       = 4'd5,
    OP_REGISTER   = 4'd6,
    OP_UNREGISTER = 4'd7,
    OP_CLEAR_ALL  = 4'd8
  } op_t;

  localparam int TYPE_SHIFT = 16;
  localparam int DIR_SHIFT  = 10;
  localparam int SLOT_BITS  = 10;
  localparam int DIR_BITS   = 6;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] handle_in;
    logic [15:0] type_id;
    logic [63:0] payload_in;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] handle_out;
    logic [63:0] payload_out;
  } rsp_t;

endpackage

FILE: design/tht_if.sv
interface tht_req_if;
  import tht_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tht_rsp_if;
  import tht_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tht_entry_mem.sv
module tht_entry_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [16:0]   wmeta,
  input  logic [63:0]   wpay,
  input  logic          wpay_en,
  input  logic [AW-1:0] raddr,
  output logic [16:0]   rmeta,
  output logic [63:0]   rpay
);
  logic [16:0] meta [DEPTH];
  logic [63:0] pay  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) meta[waddr] <= wmeta;
    if (we && wpay_en) pay[waddr] <= wpay;
    rmeta <= meta[raddr];
    rpay  <= pay[raddr];
  end
endmodule

FILE: design/typed_handle_table.sv
// Typed handle table.
// Requests arrive on the req channel (kind, handle_in, type_id, payload_in)
// and every request yields exactly one response on the rsp channel
// (ok, handle_out, payload_out). One request is worked on at a time.
// The entry store is a single-port-read memory with a registered read, so
// lookups (close, exists, get_info) and register go from READ through WAIT
// to RESP before the response is offered, and unregister from READ straight
// to RESP; a lookup of an out-of-range handle also skips WAIT. Create, first
// and next walk the store one entry per cycle, over up to DIR_COUNT*SLOT_COUNT entries.
// Clear_all sweeps the store one entry per cycle.
// After reset the block runs a clearing pass over the entry store,
// during which no request is accepted.
// A finished response is held in an output register; while the receiver
// stalls, no further request is taken until the response leaves.
module typed_handle_table
  import tht_pkg::*;
#(
  parameter int DIR_COUNT  = 4,
  parameter int SLOT_COUNT = 1024,
  parameter int TYPE_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  tht_req_if.sink   req,
  tht_rsp_if.source rsp
);
  localparam int ENTRIES = DIR_COUNT * SLOT_COUNT;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_SCAN, S_RESP
  } state_t;

  state_t          state;
  req_t            cur;
  logic [AW:0]     idx;
  logic [AW-1:0]   raddr;
  logic            we, wpay_en;
  logic [AW-1:0]   waddr;
  logic [16:0]     wmeta, rmeta;
  logic [63:0]     rpay;
  logic [TYPE_COUNT-1:0] treg;
  rsp_t            out;
  logic            rvalid;

  tht_entry_mem #(.DEPTH(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wmeta(wmeta), .wpay(cur.payload_in),
    .wpay_en(wpay_en), .raddr(raddr), .rmeta(rmeta), .rpay(rpay)
  );

  logic [15:0] ht;
  logic [9:0]  hs;
  logic [5:0]  hd;
  assign ht = cur.handle_in[31:16];
  assign hs = cur.handle_in[9:0];
  assign hd = cur.handle_in[15:10];

  function automatic logic is_reg(input logic [TYPE_COUNT-1:0] r, input logic [15:0] t);
    logic v;
    v = 1'b0;
    if (32'(t) < TYPE_COUNT) v = r[t[TW-1:0]];
    return v;
  endfunction

  function automatic logic [31:0] mk(input logic [15:0] t, input logic [AW-1:0] i);
    logic [5:0]  d;
    logic [31:0] s;
    d = '0;
    for (int k = 1; k < DIR_COUNT; k++) begin
      if (32'(i) >= 32'(k * SLOT_COUNT)) d = 6'(k);
    end
    s = 32'(i) - 32'(d) * SLOT_COUNT;
    return {t, d, s[9:0]};
  endfunction

  // Target of a lookup and start of next; start is ENTRIES when nothing.
  logic        hit_ok;
  logic [AW:0] lidx, nstart;
  logic [15:0] st_t;
  always_comb begin
    logic [6:0]  d;
    logic [10:0] s;
    hit_ok = (32'(hd) < DIR_COUNT) && (32'(hs) < SLOT_COUNT);
    lidx = (AW+1)'(32'(hd) * SLOT_COUNT + 32'(hs));
    s = 11'(hs) + 11'd1;
    d = 7'(hd);
    if (32'(s) >= SLOT_COUNT) begin
      s = '0;
      d = d + 7'd1;
    end
    if (32'(d) < DIR_COUNT) nstart = (AW+1)'(32'(d) * SLOT_COUNT + 32'(s));
    else nstart = (AW+1)'(ENTRIES);
    st_t = (op_t'(cur.kind) == OP_FIRST || op_t'(cur.kind) == OP_CREATE) ?
           cur.type_id : ht;
  end

  // Lowest free type from one, found combinationally.
  logic          free_ok;
  logic [TW-1:0] free_t;
  always_comb begin
    free_ok = 1'b0;
    free_t = '0;
    for (int i = TYPE_COUNT - 1; i >= 1; i--) begin
      if (!treg[i]) begin
        free_ok = 1'b1;
        free_t = TW'(i);
      end
    end
  end

  logic match, used;
  assign used  = rmeta[16];
  assign match = used && (rmeta[15:0] == st_t);

  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_READ) raddr = lidx[AW-1:0];
    we = 1'b0; waddr = idx[AW-1:0]; wmeta = '0; wpay_en = 1'b0;
    if (state == S_CLEAR) we = 1'b1;
    if (state == S_SCAN && rvalid) begin
      if (op_t'(cur.kind) == OP_CREATE && !used) begin
        we = 1'b1; waddr = idx[AW-1:0] - AW'(1); wmeta = {1'b1, cur.type_id};
        wpay_en = 1'b1;
      end
    end
    if (state == S_WAIT && op_t'(cur.kind) == OP_CLOSE && match && is_reg(treg, ht)) begin
      we = 1'b1; waddr = lidx[AW-1:0];
    end
  end

  assign req.ready = (state == S_IDLE) && !rsp.valid;
  assign rsp.data  = out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; idx <= '0; treg <= '0; rsp.valid <= 1'b0; rvalid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (idx == (AW+1)'(ENTRIES-1)) begin
            state <= (rvalid ? S_RESP : S_IDLE);
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          rvalid <= 1'b0;
          if (req.valid && req.ready) begin
            cur <= req.data;
            out <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          unique case (op_t'(cur.kind))
            OP_CLOSE, OP_EXISTS, OP_GET_INFO: begin
              idx <= lidx;
              state <= hit_ok ? S_WAIT : S_RESP;
            end
            OP_CREATE: begin idx <= '0; rvalid <= 1'b0; state <= S_SCAN; end
            OP_FIRST: begin
              idx <= '0; rvalid <= 1'b0;
              state <= is_reg(treg, cur.type_id) ? S_SCAN : S_RESP;
            end
            OP_NEXT: begin
              idx <= nstart; rvalid <= 1'b0;
              state <= (is_reg(treg, ht) && nstart < (AW+1)'(ENTRIES)) ? S_SCAN : S_RESP;
            end
            OP_REGISTER: begin
              out.ok <= free_ok;
              out.handle_out <= 32'(free_t);
              state <= S_WAIT;
            end
            OP_UNREGISTER: begin
              if (is_reg(treg, cur.type_id)) begin
                treg[cur.type_id[TW-1:0]] <= 1'b0; out.ok <= 1'b1;
              end
              state <= S_RESP;
            end
            OP_CLEAR_ALL: begin
              treg <= '0; out.ok <= 1'b1; idx <= '0; rvalid <= 1'b1; state <= S_CLEAR;
            end
            default: state <= S_RESP;
          endcase
        end
        S_WAIT: begin
          unique case (op_t'(cur.kind))
            OP_REGISTER: if (out.ok) treg[out.handle_out[TW-1:0]] <= 1'b1;
            OP_CLOSE: out.ok <= match && is_reg(treg, ht);
            OP_EXISTS: out.ok <= match;
            OP_GET_INFO: if (match && is_reg(treg, ht)) begin
              out.ok <= 1'b1; out.payload_out <= rpay;
            end
            default: ;
          endcase
          state <= S_RESP;
        end
        S_SCAN: begin
          rvalid <= 1'b1;
          idx <= idx + 1'b1;
          if (rvalid && ((op_t'(cur.kind) == OP_CREATE) ? !used : match)) begin
            out.ok <= 1'b1;
            out.handle_out <= mk(st_t, idx[AW-1:0] - AW'(1));
            state <= S_RESP;
          end else if (idx == (AW+1)'(ENTRIES)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          rsp.valid <= 1'b1;
          rvalid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken with response pending");
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_READ) else $error("request not started");
endmodule
